// ----- hw/rtl/circumcircle_ring_radii_macros.svh -----
// Assertion helpers for the checker file of this block.
`ifndef CIRCUMCIRCLE_RING_RADII_MACROS_SVH
`define CIRCUMCIRCLE_RING_RADII_MACROS_SVH

// Check a property on the rising edge, ignored while reset is high.
`define CRR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("crr check failed");

// Check a property on the rising edge, also while reset is high.
`define CRR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("crr check failed");

`endif

// ----- hw/rtl/crr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_pkg
// Fixed widths and constants of the circumcircle and ring radius block.
// ----------------------------------------------------------------------------
package crr_pkg;

  localparam int CENTER_W    = 34;
  localparam int RADIUS_W    = 34;
  localparam int RING_W      = 35;
  localparam int THICK_W     = 6;
  localparam int UX_W        = 35;
  localparam int DX_W        = UX_W + 1;
  localparam int UX_LO_W     = 18;
  localparam int UX_HI_W     = UX_W - UX_LO_W;
  localparam int SQ_W        = 72;
  localparam int ROOT_W      = 36;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [THICK_W-1:0] THICK_RESET = 6'd3;

  localparam logic signed [CENTER_W-1:0] CENTER_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
  localparam logic signed [CENTER_W-1:0] CENTER_MIN = {1'b1, {(CENTER_W-1){1'b0}}};
  localparam logic [RADIUS_W-1:0]        RADIUS_MAX = {RADIUS_W{1'b1}};

endpackage

// ----- hw/rtl/crr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_if
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface crr_in_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] second_x;
  logic [COORD_BITS-1:0] second_y;
  logic [COORD_BITS-1:0] third_x;
  logic [COORD_BITS-1:0] third_y;
  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface crr_out_if;
  logic               valid;
  logic               ready;
  logic               circle_valid;
  logic signed [33:0] center_x;
  logic signed [33:0] center_y;
  logic        [33:0] circle_radius;
  logic        [34:0] outer_radius;
  logic signed [34:0] inner_radius;
  modport source (output valid, circle_valid, center_x, center_y, circle_radius,
                  outer_radius, inner_radius, input ready);
  modport sink (input valid, circle_valid, center_x, center_y, circle_radius,
                outer_radius, inner_radius, output ready);
endinterface

interface crr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] line_thickness;
  modport source (output valid, line_thickness, input ready);
  modport sink (input valid, line_thickness, output ready);
endinterface

// ----- hw/rtl/crr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_front
// Four-stage front end: differences, squares, determinant and numerators.
// ----------------------------------------------------------------------------
module crr_front import crr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  crr_in_if.sink                    pts,
  input  logic                      full,
  output logic                      push,
  output logic                      push_ok,
  output logic [2*COORD_BITS+3:0]   push_det,
  output logic [3*COORD_BITS+3:0]   push_numx,
  output logic [3*COORD_BITS+3:0]   push_numy,
  output logic [COORD_BITS-1:0]     push_x1,
  output logic [COORD_BITS-1:0]     push_y1
);

  localparam int N  = COORD_BITS;
  localparam int CW = 2 * N + 2;
  localparam int DW = 2 * N + 4;
  localparam int NW = 3 * N + 4;

  logic fe;
  logic v1, v2, v3, v4;

  logic [N-1:0] x1f, y1f, x2f, y2f, x3f, y3f;
  logic [N-1:0] x1s, y1s, x2s, y2s;
  logic [N-1:0] x1t, y1t, x1u, y1u;
  logic signed [N+1:0] a2, b2, d2, e2, a3, b3, d3, e3;
  logic [2*N-1:0] qx1, qy1, qx2, qy2, qx3, qy3;
  logic signed [CW-1:0] c3, f3;
  logic signed [DW-1:0] ae4, bd4;
  logic signed [NW-1:0] ce4, fb4, af4, dc4;
  logic signed [DW-1:0] det_n;

  assign fe        = !v4 || !full;
  assign pts.ready = fe;
  assign push      = v4 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (fe) begin
      v1 <= pts.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      x1f <= pts.first_x;
      y1f <= pts.first_y;
      x2f <= pts.second_x;
      y2f <= pts.second_y;
      x3f <= pts.third_x;
      y3f <= pts.third_y;

      a2  <= {({1'b0, x2f} - {1'b0, x1f}), 1'b0};
      b2  <= {({1'b0, y2f} - {1'b0, y1f}), 1'b0};
      d2  <= {({1'b0, x3f} - {1'b0, x2f}), 1'b0};
      e2  <= {({1'b0, y3f} - {1'b0, y2f}), 1'b0};
      qx1 <= x1f * x1f;
      qy1 <= y1f * y1f;
      qx2 <= x2f * x2f;
      qy2 <= y2f * y2f;
      qx3 <= x3f * x3f;
      qy3 <= y3f * y3f;
      x1s <= x1f;
      y1s <= y1f;

      c3  <= CW'(qx2) + CW'(qy2) - CW'(qx1) - CW'(qy1);
      f3  <= CW'(qx3) + CW'(qy3) - CW'(qx2) - CW'(qy2);
      a3  <= a2;
      b3  <= b2;
      d3  <= d2;
      e3  <= e2;
      x1t <= x1s;
      y1t <= y1s;

      ae4 <= DW'(a3) * DW'(e3);
      bd4 <= DW'(b3) * DW'(d3);
      ce4 <= NW'(c3) * NW'(e3);
      fb4 <= NW'(f3) * NW'(b3);
      af4 <= NW'(a3) * NW'(f3);
      dc4 <= NW'(d3) * NW'(c3);
      x1u <= x1t;
      y1u <= y1t;
    end
  end

  // The determinant is four times the cross product: zero means collinear.
  assign det_n     = ae4 - bd4;
  assign push_det  = det_n;
  assign push_ok   = (det_n != '0);
  assign push_numx = ce4 - fb4;
  assign push_numy = af4 - dc4;
  assign push_x1   = x1u;
  assign push_y1   = y1u;

endmodule

// ----- hw/rtl/crr_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_fifo
// Small first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module crr_fifo import crr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             nonempty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [0:QUEUE_DEPTH-1];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;

  assign full     = (count == (AW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign dout     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- hw/rtl/crr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_back
// Back end: pipelined dividers, squared distance, pipelined root, ring radii.
// ----------------------------------------------------------------------------
module crr_back import crr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      q_ok,
  input  logic [2*COORD_BITS+3:0]   q_det,
  input  logic [3*COORD_BITS+3:0]   q_numx,
  input  logic [3*COORD_BITS+3:0]   q_numy,
  input  logic [COORD_BITS-1:0]     q_x1,
  input  logic [COORD_BITS-1:0]     q_y1,
  input  logic [THICK_W-1:0]        thickness,
  crr_out_if.source                 res
);

  localparam int N   = COORD_BITS;
  localparam int DW  = 2 * N + 4;
  localparam int NW  = 3 * N + 4;
  localparam int QSW = (NW + 1 > CENTER_W + 1) ? NW + 1 : CENTER_W + 1;

  localparam logic signed [QSW-1:0] CMAXW = QSW'(CENTER_MAX);
  localparam logic signed [QSW-1:0] CMINW = QSW'(CENTER_MIN);

  logic en;

  assign en    = !res.valid || res.ready;
  assign q_pop = en && q_valid;

  // Divider pipeline, one quotient bit per stage.
  logic          dv  [0:NW];
  logic          dok [0:NW];
  logic          dsx [0:NW];
  logic          dsy [0:NW];
  logic [NW-1:0] dnx [0:NW];
  logic [NW-1:0] dny [0:NW];
  logic [NW-1:0] dqx [0:NW];
  logic [NW-1:0] dqy [0:NW];
  logic [DW-1:0] drx [0:NW];
  logic [DW-1:0] dry [0:NW];
  logic [DW-1:0] ddm [0:NW];
  logic [N-1:0]  dx1 [0:NW];
  logic [N-1:0]  dy1 [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dok[0] <= q_ok;
      dsx[0] <= q_numx[NW-1] ^ q_det[DW-1];
      dsy[0] <= q_numy[NW-1] ^ q_det[DW-1];
      dnx[0] <= q_numx[NW-1] ? (~q_numx + NW'(1)) : q_numx;
      dny[0] <= q_numy[NW-1] ? (~q_numy + NW'(1)) : q_numy;
      ddm[0] <= q_det[DW-1] ? (~q_det + DW'(1)) : q_det;
      dqx[0] <= '0;
      dqy[0] <= '0;
      drx[0] <= '0;
      dry[0] <= '0;
      dx1[0] <= q_x1;
      dy1[0] <= q_y1;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW:0] tx, ty;
    logic        gx, gy;

    assign tx = {drx[k], dnx[k][NW-1]};
    assign ty = {dry[k], dny[k][NW-1]};
    assign gx = (tx >= {1'b0, ddm[k]});
    assign gy = (ty >= {1'b0, ddm[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drx[k+1] <= gx ? DW'(tx - {1'b0, ddm[k]}) : tx[DW-1:0];
        dry[k+1] <= gy ? DW'(ty - {1'b0, ddm[k]}) : ty[DW-1:0];
        dqx[k+1] <= {dqx[k][NW-2:0], gx};
        dqy[k+1] <= {dqy[k][NW-2:0], gy};
        dnx[k+1] <= {dnx[k][NW-2:0], 1'b0};
        dny[k+1] <= {dny[k][NW-2:0], 1'b0};
        ddm[k+1] <= ddm[k];
        dok[k+1] <= dok[k];
        dsx[k+1] <= dsx[k];
        dsy[k+1] <= dsy[k];
        dx1[k+1] <= dx1[k];
        dy1[k+1] <= dy1[k];
      end
    end
  end

  // Signed quotient, clamp to the center range.
  logic signed [QSW-1:0]      qxs, qys;
  logic                       p1v, p1ok;
  logic signed [CENTER_W-1:0] p1cx, p1cy;
  logic [N-1:0]               p1x1, p1y1;

  assign qxs = dsx[NW] ? -$signed(QSW'(dqx[NW])) : $signed(QSW'(dqx[NW]));
  assign qys = dsy[NW] ? -$signed(QSW'(dqy[NW])) : $signed(QSW'(dqy[NW]));

  // Distance components and their magnitudes.
  logic signed [DX_W-1:0] dxs, dys;
  logic                   p2v, p2ok;
  logic signed [CENTER_W-1:0] p2cx, p2cy;
  logic [UX_W-1:0]        p2ux, p2uy;

  assign dxs = $signed(DX_W'(p1x1)) - DX_W'(p1cx);
  assign dys = $signed(DX_W'(p1y1)) - DX_W'(p1cy);

  // Partial products of the squares.
  logic                        p3v, p3ok;
  logic signed [CENTER_W-1:0]  p3cx, p3cy;
  logic [2*UX_HI_W-1:0]        hhx, hhy;
  logic [UX_HI_W+UX_LO_W-1:0]  hlx, hly;
  logic [2*UX_LO_W-1:0]        llx, lly;

  logic                       p4v, p4ok;
  logic signed [CENTER_W-1:0] p4cx, p4cy;
  logic [SQ_W-1:0]            sqx, sqy;

  logic                       p5v, p5ok;
  logic signed [CENTER_W-1:0] p5cx, p5cy;
  logic [SQ_W-1:0]            p5s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
      p4v <= 1'b0;
      p5v <= 1'b0;
    end else if (en) begin
      p1v <= dv[NW];
      p2v <= p1v;
      p3v <= p2v;
      p4v <= p3v;
      p5v <= p4v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1ok <= dok[NW];
      p1x1 <= dx1[NW];
      p1y1 <= dy1[NW];
      if (qxs > CMAXW) begin
        p1cx <= CENTER_MAX;
      end else if (qxs < CMINW) begin
        p1cx <= CENTER_MIN;
      end else begin
        p1cx <= qxs[CENTER_W-1:0];
      end
      if (qys > CMAXW) begin
        p1cy <= CENTER_MAX;
      end else if (qys < CMINW) begin
        p1cy <= CENTER_MIN;
      end else begin
        p1cy <= qys[CENTER_W-1:0];
      end

      p2ok <= p1ok;
      p2cx <= p1cx;
      p2cy <= p1cy;
      p2ux <= dxs[DX_W-1] ? UX_W'(-dxs) : UX_W'(dxs);
      p2uy <= dys[DX_W-1] ? UX_W'(-dys) : UX_W'(dys);

      p3ok <= p2ok;
      p3cx <= p2cx;
      p3cy <= p2cy;
      hhx  <= p2ux[UX_W-1:UX_LO_W] * p2ux[UX_W-1:UX_LO_W];
      hhy  <= p2uy[UX_W-1:UX_LO_W] * p2uy[UX_W-1:UX_LO_W];
      hlx  <= p2ux[UX_W-1:UX_LO_W] * p2ux[UX_LO_W-1:0];
      hly  <= p2uy[UX_W-1:UX_LO_W] * p2uy[UX_LO_W-1:0];
      llx  <= p2ux[UX_LO_W-1:0] * p2ux[UX_LO_W-1:0];
      lly  <= p2uy[UX_LO_W-1:0] * p2uy[UX_LO_W-1:0];

      p4ok <= p3ok;
      p4cx <= p3cx;
      p4cy <= p3cy;
      sqx  <= (SQ_W'(hhx) << (2 * UX_LO_W)) + (SQ_W'(hlx) << (UX_LO_W + 1)) + SQ_W'(llx);
      sqy  <= (SQ_W'(hhy) << (2 * UX_LO_W)) + (SQ_W'(hly) << (UX_LO_W + 1)) + SQ_W'(lly);

      p5ok <= p4ok;
      p5cx <= p4cx;
      p5cy <= p4cy;
      p5s  <= sqx + sqy;
    end
  end

  // Square root pipeline, one root bit per stage, remainder kept alongside.
  logic                       sv   [0:ROOT_W];
  logic                       sok  [0:ROOT_W];
  logic signed [CENTER_W-1:0] scx  [0:ROOT_W];
  logic signed [CENTER_W-1:0] scy  [0:ROOT_W];
  logic [SQ_W-1:0]            srem [0:ROOT_W];
  logic [ROOT_W-1:0]          srt  [0:ROOT_W];

  assign sv[0]   = p5v;
  assign sok[0]  = p5ok;
  assign scx[0]  = p5cx;
  assign scy[0]  = p5cy;
  assign srem[0] = p5s;
  assign srt[0]  = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = (SQ_W'(srt[k]) << (B + 1)) + (SQ_W'(1) << (2 * B));
    assign take  = (srem[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[k+1] <= take ? (srem[k] - trial) : srem[k];
        srt[k+1]  <= take ? (srt[k] | (ROOT_W'(1) << B)) : srt[k];
        sok[k+1]  <= sok[k];
        scx[k+1]  <= scx[k];
        scy[k+1]  <= scy[k];
      end
    end
  end

  // Round to nearest, clamp, then form the ring radii.
  logic [ROOT_W:0]            rnd;
  logic                       rv, rok;
  logic signed [CENTER_W-1:0] rcx, rcy;
  logic [RADIUS_W-1:0]        rr;
  logic [THICK_W-2:0]         half;

  assign rnd  = {1'b0, srt[ROOT_W]} +
                (ROOT_W+1)'(srem[ROOT_W] > SQ_W'(srt[ROOT_W]));
  assign half = thickness[THICK_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv        <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      rv        <= sv[ROOT_W];
      res.valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rok <= sok[ROOT_W];
      rcx <= scx[ROOT_W];
      rcy <= scy[ROOT_W];
      rr  <= (rnd > (ROOT_W+1)'(RADIUS_MAX)) ? RADIUS_MAX : rnd[RADIUS_W-1:0];

      res.circle_valid <= rok;
      if (rok) begin
        res.center_x      <= rcx;
        res.center_y      <= rcy;
        res.circle_radius <= rr;
        res.outer_radius  <= RING_W'(rr) + RING_W'(half);
        res.inner_radius  <= RING_W'(rr) - RING_W'(half) - RING_W'(thickness[0]);
      end else begin
        res.center_x      <= '0;
        res.center_y      <= '0;
        res.circle_radius <= '0;
        res.outer_radius  <= '0;
        res.inner_radius  <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/circumcircle_ring_radii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_ring_radii
// Circle through three integer points, with ring radii from a thickness.
// ----------------------------------------------------------------------------
// Throughput: one point triple per cycle, sustained while the output is not
//   stalled, set by fully pipelined dividers (one quotient bit per stage)
//   and root (one root bit per stage). A triple passes the front end, the
//   queue, the dividers, the root and the rounding and output registers.
// Reset: synchronous, active high; empties all stages and the queue and
//   sets line_thickness to 3.
module circumcircle_ring_radii import crr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  crr_in_if.sink     pts,
  crr_out_if.source  res,
  crr_cfg_if.sink    cfg
);

  localparam int N  = COORD_BITS;
  localparam int DW = 2 * N + 4;
  localparam int NW = 3 * N + 4;
  localparam int QW = 1 + DW + 2 * NW + 2 * N;

  // Thickness register; the user must write it only while the block is idle;
  // the block does not enforce it; the back end reads it directly for radii.
  logic [THICK_W-1:0] thickness;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= THICK_RESET;
    end else if (cfg.valid) begin
      thickness <= cfg.line_thickness;
    end
  end

  // Front to queue.
  logic          push, full, pop, nonempty;
  logic          f_ok;
  logic [DW-1:0] f_det;
  logic [NW-1:0] f_numx, f_numy;
  logic [N-1:0]  f_x1, f_y1;
  logic [QW-1:0] q_din, q_dout;

  crr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pts       (pts),
    .full      (full),
    .push      (push),
    .push_ok   (f_ok),
    .push_det  (f_det),
    .push_numx (f_numx),
    .push_numy (f_numy),
    .push_x1   (f_x1),
    .push_y1   (f_y1)
  );

  // Pack the classified transaction for the queue.
  assign q_din = {f_ok, f_det, f_numx, f_numy, f_x1, f_y1};

  crr_fifo #(.WIDTH(QW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (q_din),
    .pop      (pop),
    .dout     (q_dout),
    .full     (full),
    .nonempty (nonempty)
  );

  // Unpack at the head of the queue and hand to the back end.
  crr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (nonempty),
    .q_pop     (pop),
    .q_ok      (q_dout[QW-1]),
    .q_det     (q_dout[QW-2 -: DW]),
    .q_numx    (q_dout[QW-2-DW -: NW]),
    .q_numy    (q_dout[QW-2-DW-NW -: NW]),
    .q_x1      (q_dout[2*N-1 -: N]),
    .q_y1      (q_dout[N-1:0]),
    .thickness (thickness),
    .res       (res)
  );

endmodule

// ----- hw/rtl/crr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "circumcircle_ring_radii_macros.svh"

module crr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        circle_valid,
  input logic [33:0] center_x,
  input logic [33:0] center_y,
  input logic [33:0] circle_radius,
  input logic [34:0] outer_radius,
  input logic [34:0] inner_radius
);

  // A stalled result holds.
  `CRR_ASSERT(a_stall_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(center_x) && $stable(circle_radius) && $stable(inner_radius))

  // Collinear points give an all-zero result.
  `CRR_ASSERT(a_collinear_zero, clk, rst, res_valid && !circle_valid |-> center_x == 34'd0 && center_y == 34'd0 && circle_radius == 34'd0 && outer_radius == 35'd0 && inner_radius == 35'd0)

  // The outer radius never falls below the circle radius.
  `CRR_ASSERT(a_outer_ge, clk, rst, res_valid && circle_valid |-> outer_radius >= {1'b0, circle_radius})

  // Reset empties the pipeline.
  `CRR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid)

endmodule

bind circumcircle_ring_radii crr_checker u_crr_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .circle_valid  (res.circle_valid),
  .center_x      (res.center_x),
  .center_y      (res.center_y),
  .circle_radius (res.circle_radius),
  .outer_radius  (res.outer_radius),
  .inner_radius  (res.inner_radius)
);
